FILE: src/md5_pkg.sv
// Shared types, constants and round functions for the MD5 stream hasher.
// Used by md5_front, md5_core and md5_stream_hasher; depends on nothing.
package md5_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [3:0] LEN_LO_WORD = 4'd14;
    localparam logic [3:0] LEN_HI_WORD = 4'd15;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } item_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_CINIT = 7'b0000100,
        S_ROUND = 7'b0001000,
        S_ADD   = 7'b0010000,
        S_EMIT0 = 7'b0100000,
        S_EMIT1 = 7'b1000000
    } core_state_t;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] i4;
        logic [3:0] g;
        i4 = r[3:0];
        case (r[5:4])
            2'd0: g = i4;
            2'd1: g = i4 * 4'd5 + 4'd1;
            2'd2: g = i4 * 4'd3 + 4'd5;
            2'd3: g = i4 * 4'd7;
            default: g = i4;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (grp)
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (d & b) | (~d & c);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
            default: f = 32'h0;
        endcase
        return f;
    endfunction

endpackage

FILE: src/md5_stream_hasher.sv
// Top level of the MD5 stream hasher: front queue plus hashing back end.
// Depends on md5_pkg, md5_front, md5_core (and md5_ram inside md5_core).
//
//   channel | direction | handshake         | payload
//   s_      | in        | s_valid, s_ready  | s_data_byte[7:0], s_byte_valid, s_last
//   m_      | out       | m_valid, m_ready  | m_digest_half[63:0], m_final_half
//
// Each byte item is packed into the block RAM; the 64th byte of a block also starts
// the compression (one round per cycle, message words read from the block RAM).
// A closing item adds up to 16 padding writes and a compression, or twice that when
// the padding spills into a second block, and then one output per digest half.
// Reset is synchronous on aresetn and restores the initial chaining words and counts.
// The input queue (QUEUE_DEPTH entries, two by default) accepts items while the back end
// compresses or m_ready is low, and s_ready drops once all entries are taken.
module md5_stream_hasher #(
    parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_valid,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_half,
    output logic        m_final_half
);
    import md5_pkg::*;

    item_t s_item;
    item_t q_item;
    logic  q_valid;
    logic  q_ready;

    assign s_item.data_byte  = s_data_byte;
    assign s_item.byte_valid = s_byte_valid;
    assign s_item.last       = s_last;

    md5_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .q_valid(q_valid),
        .q_ready(q_ready),
        .q_item (q_item)
    );

    md5_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digest_half(m_digest_half),
        .m_final_half (m_final_half)
    );

endmodule

FILE: src/md5_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the message block as 32-bit words in md5_core.
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/md5_front.sv
// Front end: accepts input items, drops items that carry neither a byte nor an end,
// and queues the rest for the back end. Depends on md5_pkg.
module md5_front #(
    parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  md5_pkg::item_t s_item,
    output logic           q_valid,
    input  logic           q_ready,
    output md5_pkg::item_t q_item
);
    import md5_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign s_ready = (count_reg != CNT_FULL);
    assign push    = s_valid && s_ready && (s_item.byte_valid || s_item.last);
    assign q_valid = (count_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= s_item;
        end
    end

endmodule

FILE: src/md5_core.sv
// Back end: packs bytes into the block RAM, pads, runs one MD5 round per cycle
// and delivers the digest through an output register. Depends on md5_pkg, md5_ram.
module md5_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  md5_pkg::item_t q_item,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [63:0]    m_digest_half,
    output logic           m_final_half
);
    import md5_pkg::*;

    core_state_t state_reg, state_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [63:0] count_reg, count_next;
    logic [5:0]  fill_reg, fill_next;
    logic [3:0]  wptr_reg, wptr_next;
    logic        mark_reg, mark_next;
    logic        spill_reg, spill_next;
    logic        in_pad_reg, in_pad_next;
    logic        pend_reg, pend_next;
    logic [5:0]  round_reg, round_next;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] word_reg, word_next;
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [63:0] out_data_reg, out_data_next;
    logic        out_final_reg, out_final_next;

    logic        ram_we;
    logic [3:0]  ram_wa;
    logic [31:0] ram_wd;
    logic [3:0]  ram_ra;
    logic [31:0] ram_rd;

    logic [31:0] word_upd;
    logic [31:0] partial_word;
    logic [31:0] pad_word;
    logic [5:0]  fill_new;
    logic [31:0] round_sum;
    logic [63:0] rot_wide;
    logic        out_free;

    md5_ram #(
        .WIDTH(32),
        .DEPTH(16)
    ) u_block_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_wa),
        .wr_data(ram_wd),
        .rd_addr(ram_ra),
        .rd_data(ram_rd)
    );

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            word_upd[8*j +: 8] = (fill_reg[1:0] == 2'(j)) ? q_item.data_byte
                                                          : word_reg[8*j +: 8];
            if (2'(j) < fill_reg[1:0]) begin
                partial_word[8*j +: 8] = word_reg[8*j +: 8];
            end else if (2'(j) == fill_reg[1:0]) begin
                partial_word[8*j +: 8] = PAD_BYTE;
            end else begin
                partial_word[8*j +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        if (mark_reg) begin
            pad_word = partial_word;
        end else if (!spill_reg && wptr_reg == LEN_LO_WORD) begin
            pad_word = count_reg[31:0];
        end else if (!spill_reg && wptr_reg == LEN_HI_WORD) begin
            pad_word = count_reg[63:32];
        end else begin
            pad_word = 32'h0;
        end
    end

    assign fill_new  = q_item.byte_valid ? fill_reg + 6'd1 : fill_reg;
    assign round_sum = a_reg + round_f(round_reg[5:4], b_reg, c_reg, d_reg)
                     + round_k(round_reg) + ram_rd;
    assign rot_wide  = {round_sum, round_sum} << rot_amount(round_reg);
    assign out_free  = !out_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        wptr_next      = wptr_reg;
        mark_next      = mark_reg;
        spill_next     = spill_reg;
        in_pad_next    = in_pad_reg;
        pend_next      = pend_reg;
        round_next     = round_reg;
        word_next      = word_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        out_final_next = out_final_reg;
        q_ready        = 1'b0;
        ram_we         = 1'b0;
        ram_wa         = '0;
        ram_wd         = '0;
        ram_ra         = '0;

        case (state_reg)
            S_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    if (q_item.byte_valid) begin
                        word_next  = word_upd;
                        fill_next  = fill_new;
                        count_next = count_reg + 64'd8;
                        if (fill_reg[1:0] == 2'd3) begin
                            ram_we = 1'b1;
                            ram_wa = fill_reg[5:2];
                            ram_wd = word_upd;
                        end
                    end
                    if (q_item.last) begin
                        wptr_next  = fill_new[5:2];
                        spill_next = (fill_new[5:3] == 3'd7);
                        mark_next  = 1'b1;
                    end
                    if (q_item.byte_valid && fill_new == 6'd0) begin
                        pend_next  = q_item.last;
                        state_next = S_CINIT;
                    end else if (q_item.last) begin
                        in_pad_next = 1'b1;
                        state_next  = S_PAD;
                    end
                end
            end
            S_PAD: begin
                ram_we    = 1'b1;
                ram_wa    = wptr_reg;
                ram_wd    = pad_word;
                mark_next = 1'b0;
                wptr_next = wptr_reg + 4'd1;
                if (wptr_reg == LEN_HI_WORD) begin
                    state_next = S_CINIT;
                end
            end
            S_CINIT: begin
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                round_next = '0;
                ram_ra     = msg_index(6'd0);
                state_next = S_ROUND;
            end
            S_ROUND: begin
                a_next     = d_reg;
                d_next     = c_reg;
                c_next     = b_reg;
                b_next     = b_reg + rot_wide[63:32];
                round_next = round_reg + 6'd1;
                ram_ra     = msg_index(round_reg + 6'd1);
                if (round_reg == LAST_ROUND) begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (in_pad_reg && spill_reg) begin
                    spill_next = 1'b0;
                    wptr_next  = '0;
                    state_next = S_PAD;
                end else if (in_pad_reg) begin
                    state_next = S_EMIT0;
                end else if (pend_reg) begin
                    pend_next   = 1'b0;
                    in_pad_next = 1'b1;
                    state_next  = S_PAD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT0: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {chain_reg[1], chain_reg[0]};
                    out_final_next = 1'b0;
                    state_next     = S_EMIT1;
                end
            end
            S_EMIT1: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {chain_reg[3], chain_reg[2]};
                    out_final_next = 1'b1;
                    chain_next[0]  = INIT_A;
                    chain_next[1]  = INIT_B;
                    chain_next[2]  = INIT_C;
                    chain_next[3]  = INIT_D;
                    count_next     = '0;
                    fill_next      = '0;
                    in_pad_next    = 1'b0;
                    pend_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            chain_reg[0]  <= INIT_A;
            chain_reg[1]  <= INIT_B;
            chain_reg[2]  <= INIT_C;
            chain_reg[3]  <= INIT_D;
            count_reg     <= '0;
            fill_reg      <= '0;
            wptr_reg      <= '0;
            mark_reg      <= 1'b0;
            spill_reg     <= 1'b0;
            in_pad_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            wptr_reg      <= wptr_next;
            mark_reg      <= mark_next;
            spill_reg     <= spill_next;
            in_pad_reg    <= in_pad_next;
            pend_reg      <= pend_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg      <= word_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        c_reg         <= c_next;
        d_reg         <= d_next;
        out_data_reg  <= out_data_next;
        out_final_reg <= out_final_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_digest_half = out_data_reg;
    assign m_final_half  = out_final_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for md5_stream_hasher: drives byte items, predicts each digest
// with its own MD5 model, and compares both digest halves. Depends on the md5 RTL only.
module tb_top;

    localparam int CLK_HALF = 5;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1900;
    localparam int TAIL_CYCLES = 300;
    localparam int CYCLE_LIMIT = 2000000;

    localparam logic [31:0] CHAIN_INIT [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int SHIFT_AMT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    localparam int PAD_LENGTHS [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 121, 128};

    typedef struct packed {
        logic [63:0] digest_half;
        logic        final_half;
    } digest_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_byte_valid = 1'b0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_digest_half;
    logic        m_final_half;

    logic [7:0]   msg_block [64];
    logic [31:0]  chain_w [4];
    logic [63:0]  msg_bits;
    logic [5:0]   fill_pos;
    digest_item_t digest_q [$];
    digest_item_t exp_half;

    int fail_count = 0;
    int cycle_cnt = 0;
    int burst_left = 0;
    int item_total = 0;

    md5_stream_hasher dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_byte_valid  (s_byte_valid),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_half (m_digest_half),
        .m_final_half  (m_final_half)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic void md5_restart();
        for (int i = 0; i < 64; i++) begin
            msg_block[i] = 8'h00;
        end
        for (int i = 0; i < 4; i++) begin
            chain_w[i] = CHAIN_INIT[i];
        end
        msg_bits = 64'd0;
        fill_pos = 6'd0;
    endfunction

    function automatic void md5_compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t, sum;
        int g, grp, sh;
        for (int i = 0; i < 16; i++) begin
            w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
        end
        a = chain_w[0];
        b = chain_w[1];
        c = chain_w[2];
        d = chain_w[3];
        for (int i = 0; i < 64; i++) begin
            grp = i / 16;
            case (grp)
                0: begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = (5 * i + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            sh = SHIFT_AMT[grp * 4 + i % 4];
            sum = a + f + SINE_K[i] + w[g];
            t = d;
            d = c;
            c = b;
            b = b + ((sum << sh) | (sum >> (32 - sh)));
            a = t;
        end
        chain_w[0] = chain_w[0] + a;
        chain_w[1] = chain_w[1] + b;
        chain_w[2] = chain_w[2] + c;
        chain_w[3] = chain_w[3] + d;
    endfunction

    function automatic void md5_absorb(input logic [7:0] data, input logic bv,
                                       input logic lst);
        int k;
        if (bv) begin
            msg_block[fill_pos] = data;
            fill_pos = fill_pos + 6'd1;
            msg_bits = msg_bits + 64'd8;
            if (fill_pos == 6'd0) begin
                md5_compress_block();
            end
        end
        if (lst) begin
            k = fill_pos;
            msg_block[k] = 8'h80;
            k++;
            if (k > 56) begin
                while (k < 64) begin
                    msg_block[k] = 8'h00;
                    k++;
                end
                md5_compress_block();
                k = 0;
            end
            while (k < 56) begin
                msg_block[k] = 8'h00;
                k++;
            end
            for (int i = 0; i < 8; i++) begin
                msg_block[56 + i] = msg_bits[8*i +: 8];
            end
            md5_compress_block();
            digest_q.push_back('{digest_half: {chain_w[1], chain_w[0]}, final_half: 1'b0});
            digest_q.push_back('{digest_half: {chain_w[3], chain_w[2]}, final_half: 1'b1});
            md5_restart();
        end
    endfunction

    task automatic send_item(input logic [7:0] data, input logic bv, input logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data_byte <= data;
        s_byte_valid <= bv;
        s_last <= lst;
        do @(posedge aclk); while (!s_ready);
        md5_absorb(data, bv, lst);
    endtask

    task automatic wait_for_digests();
        s_valid <= 1'b0;
        do @(posedge aclk); while (digest_q.size() != 0);
    endtask

    task automatic test_empty_message();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);
    endtask

    task automatic test_single_byte_extremes();
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h5a, 1'b1, 1'b0);
        send_item(8'ha5, 1'b1, 1'b1);
    endtask

    task automatic test_idle_and_closing_items();
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        wait_for_digests();
    endtask

    task automatic test_random_messages();
        int msg_len;
        int pick;
        bit split_close;
        bit drained;
        drained = 1'b0;
        while (item_total < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                msg_len = $urandom_range(0, 70);
            end else if (pick < 90) begin
                msg_len = PAD_LENGTHS[$urandom_range(0, 11)];
            end else if (pick < 98) begin
                msg_len = $urandom_range(71, 200);
            end else begin
                msg_len = $urandom_range(256, 700);
            end
            split_close = (msg_len == 0) || ($urandom_range(0, 1) == 1);
            for (int j = 0; j < msg_len; j++) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    item_total++;
                end
                send_item(8'($urandom_range(0, 255)), 1'b1,
                          (j == msg_len - 1) && !split_close);
                item_total++;
            end
            if (split_close) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                item_total++;
            end
            if (!drained && item_total >= RANDOM_ITEMS / 2) begin
                wait_for_digests();
                drained = 1'b1;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                $error("digest_half: no item expected, actual %h", m_digest_half);
                fail_count++;
            end else begin
                exp_half = digest_q.pop_front();
                if (m_digest_half !== exp_half.digest_half) begin
                    $error("digest_half: expected %h, actual %h",
                           exp_half.digest_half, m_digest_half);
                    fail_count++;
                end
                if (m_final_half !== exp_half.final_half) begin
                    $error("final_half: expected %b, actual %b",
                           exp_half.final_half, m_final_half);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int run;
        @(posedge aclk);
        forever begin
            run = $urandom_range(1, 40);
            case ($urandom_range(0, 2))
                0: begin
                    m_ready <= 1'b1;
                    repeat (run) @(posedge aclk);
                end
                1: begin
                    repeat (run) begin
                        m_ready <= 1'($urandom_range(0, 1));
                        @(posedge aclk);
                    end
                end
                default: begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge aclk);
                    m_ready <= 1'b1;
                    repeat (run) @(posedge aclk);
                end
            endcase
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("[md5_stream_hasher] ERROR");
        $finish;
    end

    initial begin
        md5_restart();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_message();
        test_single_byte_extremes();
        test_idle_and_closing_items();
        test_random_messages();
        wait_for_digests();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[md5_stream_hasher] OK");
        end else begin
            $display("[md5_stream_hasher] ERROR");
        end
        $finish;
    end

endmodule

FILE: md5_stream_hasher.f
src/md5_pkg.sv
src/md5_ram.sv
src/md5_front.sv
src/md5_core.sv
src/md5_stream_hasher.sv
tb/tb_top.sv
